// ===== rtl/bmsa_pkg.sv =====
// types, constants and codes shared by the binned mean and standard error accumulator
package bmsa_pkg;

    localparam int MAX_BINS_DEFAULT = 64;
    localparam logic [6:0] BIN_LIMIT_RESET = 7'd40;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [22:0] ERR_MAX = 23'h7FFFFF;
    localparam logic [23:0] MEAN_POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] MEAN_NEG_MIN = 24'h800000;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_READ = 1'b1;
    localparam logic CFG_REG_BIN_LIMIT = 1'b0;

    typedef struct packed {
        logic              cmd;
        logic signed [23:0] truth_energy;
        logic signed [23:0] cluster_energy;
        logic signed [23:0] core_energy;
        logic        [5:0]  read_bin;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic        [15:0] sample_count;
        logic signed [23:0] mean_cluster;
        logic        [22:0] error_cluster;
        logic signed [23:0] mean_core;
        logic        [22:0] error_core;
    } result_t;

    typedef struct packed {
        logic [15:0] count;
        logic [39:0] cluster_sum;
        logic [61:0] cluster_square_sum;
        logic [39:0] core_sum;
        logic [61:0] core_square_sum;
    } entry_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ACC, ST_LOAD, ST_DEN1, ST_DEN2, ST_MEAN,
        ST_MA, ST_MB, ST_EDIV, ST_SQRT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AR_MUL, AR_DIV, AR_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

// ===== rtl/bmsa_arith.sv =====
// shared bit-serial multiplier, divider and square root unit
module bmsa_arith
(
    input  logic                clk,
    input  logic                rst_n,
    input  bmsa_pkg::arith_req_t req,
    input  logic [127:0]        opa,
    input  logic [63:0]         opb,
    output logic                done,
    output logic [127:0]        res
);

    logic                busy_reg, busy_next;
    bmsa_pkg::arith_op_t op_reg, op_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [127:0]        x_reg, x_next;
    logic [63:0]         y_reg, y_next;
    logic [127:0]        acc_reg, acc_next;
    logic [63:0]         rem_reg, rem_next;
    logic                over_reg, over_next;
    logic                done_reg, done_next;

    logic [64:0] rem_sh;
    logic        qbit;
    logic [64:0] root_try;
    logic        last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= bmsa_pkg::AR_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        over_reg <= over_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        over_next = over_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, x_reg[127]};
        qbit      = (rem_sh >= {1'b0, y_reg});
        root_try  = {1'b0, acc_reg[63:0]} + {1'b0, y_reg};
        last      = 1'b0;

        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            rem_next  = '0;
            over_next = 1'b0;
            x_next    = opa;
            y_next    = opb;
            if (req.op == bmsa_pkg::AR_SQRT)
            begin
                x_next = {64'b0, opa[63:0]};
                y_next = 64'h4000_0000_0000_0000;
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 8'd1;
            unique case (op_reg)
                bmsa_pkg::AR_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[126:0], 1'b0};
                    y_next = {1'b0, y_reg[63:1]};
                    last   = (cnt_reg == 8'd63);
                end
                bmsa_pkg::AR_DIV:
                begin
                    x_next   = {x_reg[126:0], 1'b0};
                    rem_next = qbit ? 64'(rem_sh - {1'b0, y_reg}) : rem_sh[63:0];
                    if (cnt_reg < 8'd64)
                    begin
                        over_next = over_reg | qbit;
                    end
                    else
                    begin
                        acc_next = {acc_reg[126:0], qbit};
                    end
                    last = (cnt_reg == 8'd127);
                end
                bmsa_pkg::AR_SQRT:
                begin
                    if ({1'b0, x_reg[63:0]} >= root_try)
                    begin
                        x_next   = {64'b0, 64'(x_reg[63:0] - root_try[63:0])};
                        acc_next = {64'b0, 64'({1'b0, acc_reg[63:1]} + y_reg)};
                    end
                    else
                    begin
                        acc_next = {64'b0, 1'b0, acc_reg[63:1]};
                    end
                    y_next = {2'b0, y_reg[63:2]};
                    last   = (cnt_reg == 8'd31);
                end
                default:
                begin
                    last = 1'b1;
                end
            endcase
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == bmsa_pkg::AR_DIV && over_reg) ? {64'b0, {64{1'b1}}} : acc_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_reg)
        else $error("arith done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) $rose(done) |-> $past(busy_reg))
        else $error("arith done without a running operation");
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && op_reg == bmsa_pkg::AR_SQRT |-> cnt_reg < 8'd32)
        else $error("square root ran past its last step");

endmodule

// ===== rtl/binned_mean_stderr_accumulator_top.sv =====
// binned mean and standard error accumulator: bin memory, sequencer and config port
// accumulate word: memory read, then write back, then the result is registered
// read word: the result waits on the bit-serial multiply, divide and root
// unit: two 64-step multiplies, then per energy a 128-step divide, two 64-step multiplies,
// a 128-step divide and a 32-step root, each with a start and a done strobe; one word at a time
// after reset the bin memory is cleared entry by entry, no word is accepted meanwhile
module binned_mean_stderr_accumulator_top
#(
    parameter int MAX_BINS = bmsa_pkg::MAX_BINS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             item_valid,
    output logic             item_stall,
    input  bmsa_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output bmsa_pkg::result_t result
);

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    bmsa_pkg::state_t state_reg, state_next;
    logic [6:0]   bin_limit_reg;
    logic [AW-1:0] clr_reg, clr_next;
    logic         launch_reg, launch_next;
    logic         ch_reg, ch_next;
    logic         cmd_reg;
    logic         ok_reg, ok_next;
    logic [AW-1:0] addr_reg;
    logic [47:0]  sqc_reg, sqk_reg;
    logic signed [23:0] c_reg, k_reg;
    logic [15:0]  n_reg;
    logic [39:0]  s1c_reg, s1k_reg;
    logic [61:0]  s2c_reg, s2k_reg;
    logic [47:0]  den_reg;
    logic [77:0]  a_reg;
    logic [79:0]  b_reg;
    logic [63:0]  q_reg;
    logic [23:0]  meanc_reg, meank_reg;
    logic [22:0]  errc_reg, errk_reg;
    logic         res_valid_reg;
    bmsa_pkg::result_t res_reg;

    bmsa_pkg::entry_t mem [MAX_BINS];
    bmsa_pkg::entry_t rd_q;
    bmsa_pkg::entry_t wr_data;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic         accept;
    logic [11:0]  lim;
    logic [23:0]  tmag;
    logic [11:0]  bmag;
    logic         acc_ok;
    logic         read_ok;
    logic         cfg_we;

    bmsa_pkg::arith_req_t ar_req;
    logic [127:0] ar_opa;
    logic [63:0]  ar_opb;
    logic         ar_done;
    logic [127:0] ar_res;

    logic [39:0]  s1;
    logic [61:0]  s2;
    logic [39:0]  mag;
    logic [40:0]  mq;
    logic [23:0]  mean_val;
    logic [22:0]  err_val;
    logic         gt;
    logic         out_free;
    bmsa_pkg::result_t res_build;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == bmsa_pkg::CFG_REG_BIN_LIMIT);
    assign prdata = (paddr[2] == bmsa_pkg::CFG_REG_BIN_LIMIT) ? {25'b0, bin_limit_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_limit_reg <= bmsa_pkg::BIN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            bin_limit_reg <= pwdata[6:0];
        end
    end

    // bin selection
    assign lim     = ({5'b0, bin_limit_reg} < 12'(MAX_BINS)) ? {5'b0, bin_limit_reg}
                                                            : 12'(MAX_BINS);
    assign tmag    = item.truth_energy[23] ? 24'(-item.truth_energy) : item.truth_energy;
    assign bmag    = tmag[23:12];
    assign acc_ok  = !(item.truth_energy[23] && bmag != 12'd0) && (bmag < lim);
    assign read_ok = {6'b0, item.read_bin} < lim;
    assign rd_addr = (item.cmd == bmsa_pkg::CMD_READ) ? AW'(item.read_bin) : AW'(bmag);

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != bmsa_pkg::ST_IDLE);

    // bin memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    always_comb
    begin
        wr_data = '0;
        wr_addr = clr_reg;
        mem_we  = 1'b0;
        if (state_reg == bmsa_pkg::ST_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == bmsa_pkg::ST_ACC)
        begin
            wr_addr = addr_reg;
            mem_we  = ok_reg && (rd_q.count != bmsa_pkg::COUNT_MAX);
            wr_data.count              = rd_q.count + 16'd1;
            wr_data.cluster_sum        = rd_q.cluster_sum + {{16{c_reg[23]}}, c_reg};
            wr_data.cluster_square_sum = rd_q.cluster_square_sum + {14'b0, sqc_reg};
            wr_data.core_sum           = rd_q.core_sum + {{16{k_reg[23]}}, k_reg};
            wr_data.core_square_sum    = rd_q.core_square_sum + {14'b0, sqk_reg};
        end
    end

    // operands for the shared arithmetic unit
    assign s1  = ch_reg ? s1k_reg : s1c_reg;
    assign s2  = ch_reg ? s2k_reg : s2c_reg;
    assign mag = s1[39] ? 40'(-s1) : s1;
    assign gt  = {2'b0, a_reg} > b_reg;

    always_comb
    begin
        ar_req.start = launch_reg;
        ar_req.op    = bmsa_pkg::AR_MUL;
        ar_opa       = '0;
        ar_opb       = '0;
        unique case (state_reg)
            bmsa_pkg::ST_DEN1:
            begin
                ar_opa = {112'b0, n_reg};
                ar_opb = {48'b0, n_reg};
            end
            bmsa_pkg::ST_DEN2:
            begin
                ar_opa = {80'b0, den_reg};
                ar_opb = {48'b0, 16'(n_reg - 16'd1)};
            end
            bmsa_pkg::ST_MEAN:
            begin
                ar_req.op = bmsa_pkg::AR_DIV;
                ar_opa    = {86'b0, 42'({1'b0, mag, 1'b0} + {26'b0, n_reg})};
                ar_opb    = {47'b0, n_reg, 1'b0};
            end
            bmsa_pkg::ST_MA:
            begin
                ar_opa = {112'b0, n_reg};
                ar_opb = {2'b0, s2};
            end
            bmsa_pkg::ST_MB:
            begin
                ar_opa = {88'b0, mag};
                ar_opb = {24'b0, mag};
            end
            bmsa_pkg::ST_EDIV:
            begin
                ar_req.op = bmsa_pkg::AR_DIV;
                ar_opa    = {48'b0, 80'({2'b0, a_reg} - b_reg)};
                ar_opb    = {16'b0, den_reg};
            end
            bmsa_pkg::ST_SQRT:
            begin
                ar_req.op = bmsa_pkg::AR_SQRT;
                ar_opa    = {64'b0, q_reg};
            end
            default:
            begin
                ar_req.start = 1'b0;
            end
        endcase
    end

    bmsa_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ar_req),
        .opa   (ar_opa),
        .opb   (ar_opb),
        .done  (ar_done),
        .res   (ar_res)
    );

    assign mq = ar_res[40:0];
    always_comb
    begin
        if (!s1[39])
        begin
            mean_val = (mq > 41'(bmsa_pkg::MEAN_POS_MAX)) ? bmsa_pkg::MEAN_POS_MAX : mq[23:0];
        end
        else
        begin
            mean_val = (mq > 41'h800000) ? bmsa_pkg::MEAN_NEG_MIN : 24'(-mq[23:0]);
        end
        if (!gt)
        begin
            err_val = '0;
        end
        else if (ar_res[63:0] > 64'(bmsa_pkg::ERR_MAX))
        begin
            err_val = bmsa_pkg::ERR_MAX;
        end
        else
        begin
            err_val = ar_res[22:0];
        end
    end

    // result assembly
    always_comb
    begin
        res_build = '0;
        res_build.accepted = ok_reg;
        if (cmd_reg == bmsa_pkg::CMD_READ && ok_reg)
        begin
            res_build.sample_count = n_reg;
            if (n_reg != 16'd0)
            begin
                res_build.mean_cluster = meanc_reg;
                res_build.mean_core    = meank_reg;
            end
            if (n_reg > 16'd1)
            begin
                res_build.error_cluster = errc_reg;
                res_build.error_core    = errk_reg;
            end
        end
    end

    assign out_free = !res_valid_reg || !result_stall;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmsa_pkg::ST_CLEAR;
            clr_reg       <= '0;
            launch_reg    <= 1'b0;
            ch_reg        <= 1'b0;
            ok_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            launch_reg <= launch_next;
            ch_reg     <= ch_next;
            ok_reg     <= ok_next;
            if (state_reg == bmsa_pkg::ST_DONE && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= item.cmd;
            addr_reg <= rd_addr;
            c_reg    <= item.cluster_energy;
            k_reg    <= item.core_energy;
            sqc_reg  <= 48'(item.cluster_energy * item.cluster_energy);
            sqk_reg  <= 48'(item.core_energy * item.core_energy);
        end
        if (state_reg == bmsa_pkg::ST_LOAD)
        begin
            n_reg   <= rd_q.count;
            s1c_reg <= rd_q.cluster_sum;
            s2c_reg <= rd_q.cluster_square_sum;
            s1k_reg <= rd_q.core_sum;
            s2k_reg <= rd_q.core_square_sum;
        end
        if (ar_done)
        begin
            unique case (state_reg)
                bmsa_pkg::ST_DEN1, bmsa_pkg::ST_DEN2: den_reg <= ar_res[47:0];
                bmsa_pkg::ST_MA:   a_reg <= ar_res[77:0];
                bmsa_pkg::ST_MB:   b_reg <= ar_res[79:0];
                bmsa_pkg::ST_EDIV: q_reg <= ar_res[63:0];
                bmsa_pkg::ST_MEAN:
                begin
                    if (ch_reg)
                    begin
                        meank_reg <= mean_val;
                    end
                    else
                    begin
                        meanc_reg <= mean_val;
                    end
                end
                bmsa_pkg::ST_SQRT:
                begin
                    if (ch_reg)
                    begin
                        errk_reg <= err_val;
                    end
                    else
                    begin
                        errc_reg <= err_val;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == bmsa_pkg::ST_DONE && out_free)
        begin
            res_reg <= res_build;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        launch_next = 1'b0;
        ch_next     = ch_reg;
        ok_next     = ok_reg;
        unique case (state_reg)
            bmsa_pkg::ST_CLEAR:
            begin
                clr_next = AW'(clr_reg + 1'b1);
                if (clr_reg == AW'(MAX_BINS - 1))
                begin
                    state_next = bmsa_pkg::ST_IDLE;
                end
            end
            bmsa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == bmsa_pkg::CMD_READ)
                    begin
                        ok_next    = read_ok;
                        state_next = bmsa_pkg::ST_LOAD;
                    end
                    else
                    begin
                        ok_next    = acc_ok;
                        state_next = bmsa_pkg::ST_ACC;
                    end
                end
            end
            bmsa_pkg::ST_ACC:
            begin
                ok_next    = ok_reg && (rd_q.count != bmsa_pkg::COUNT_MAX);
                state_next = bmsa_pkg::ST_DONE;
            end
            bmsa_pkg::ST_LOAD:
            begin
                ch_next = 1'b0;
                if (ok_reg)
                begin
                    state_next  = bmsa_pkg::ST_DEN1;
                    launch_next = 1'b1;
                end
                else
                begin
                    state_next = bmsa_pkg::ST_DONE;
                end
            end
            bmsa_pkg::ST_DEN1, bmsa_pkg::ST_DEN2, bmsa_pkg::ST_MEAN, bmsa_pkg::ST_MA,
            bmsa_pkg::ST_MB, bmsa_pkg::ST_EDIV:
            begin
                if (ar_done)
                begin
                    launch_next = 1'b1;
                    unique case (state_reg)
                        bmsa_pkg::ST_DEN1: state_next = bmsa_pkg::ST_DEN2;
                        bmsa_pkg::ST_DEN2: state_next = bmsa_pkg::ST_MEAN;
                        bmsa_pkg::ST_MEAN: state_next = bmsa_pkg::ST_MA;
                        bmsa_pkg::ST_MA:   state_next = bmsa_pkg::ST_MB;
                        bmsa_pkg::ST_MB:   state_next = bmsa_pkg::ST_EDIV;
                        default:           state_next = bmsa_pkg::ST_SQRT;
                    endcase
                end
            end
            bmsa_pkg::ST_SQRT:
            begin
                if (ar_done)
                begin
                    if (!ch_reg)
                    begin
                        ch_next     = 1'b1;
                        state_next  = bmsa_pkg::ST_MEAN;
                        launch_next = 1'b1;
                    end
                    else
                    begin
                        state_next = bmsa_pkg::ST_DONE;
                    end
                end
            end
            bmsa_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bmsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == bmsa_pkg::ST_DONE))
        else $error("result word raised outside the done state");
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == bmsa_pkg::ST_ACC || state_reg == bmsa_pkg::ST_CLEAR))
        else $error("bin memory written outside accumulate or clear");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bmsa_pkg::ST_ACC || state_reg == bmsa_pkg::ST_LOAD))
        else $error("accepted word did not start memory work");
    assert property (@(posedge clk) disable iff (!rst_n)
        ar_done |-> (state_reg != bmsa_pkg::ST_IDLE && state_reg != bmsa_pkg::ST_DONE))
        else $error("arithmetic finished with no read in progress");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the binned mean and standard error accumulator
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS = bmsa_pkg::MAX_BINS_DEFAULT;
    localparam int IDLE_LIMIT = 8000;
    localparam int ITEM_W = $bits(bmsa_pkg::item_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    bmsa_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    bmsa_pkg::result_t result;

    binned_mean_stderr_accumulator_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    // predictor state
    logic [15:0] bin_cnt [NBINS];
    logic signed [39:0] clus_sum [NBINS];
    logic [61:0] clus_sq [NBINS];
    logic signed [39:0] core_sum [NBINS];
    logic [61:0] core_sq [NBINS];
    logic [6:0] bin_lim;

    bmsa_pkg::result_t pending_results[$];
    int errors = 0;
    int hold_cycles = 0;
    bit item_taken;
    bit result_taken;

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic signed [23:0] bin_mean(logic signed [39:0] s, logic [15:0] n);
        logic signed [63:0] s64;
        logic [63:0] mag;
        logic [63:0] q;
        logic signed [64:0] m;
        if (n == 0)
            return '0;
        s64 = s;
        mag = (s64 < 0) ? 64'(-s64) : 64'(s64);
        q = (mag * 2 + 64'(n)) / (64'(n) * 2);
        m = (s64 < 0) ? -$signed({1'b0, q}) : $signed({1'b0, q});
        if (m > 65'sd8388607)
            m = 65'sd8388607;
        if (m < -65'sd8388608)
            m = -65'sd8388608;
        return m[23:0];
    endfunction

    function automatic logic [22:0] bin_stderr(logic signed [39:0] s, logic [61:0] sq,
                                               logic [15:0] n);
        logic signed [63:0] s64;
        logic [127:0] mag, a, b, d, den, q, cand;
        logic [32:0] r;
        if (n <= 1)
            return '0;
        s64 = s;
        mag = (s64 < 0) ? 128'(-s64) : 128'(s64);
        a = 128'(n) * 128'(sq);
        b = mag * mag;
        if (a <= b)
            return '0;
        d = a - b;
        den = 128'(n) * 128'(n) * 128'(n - 16'd1);
        q = d / den;
        if (q > 128'(64'hFFFF_FFFF_FFFF_FFFF))
            q = 128'(64'hFFFF_FFFF_FFFF_FFFF);
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = 128'(r | (33'd1 << i));
            if (cand * cand <= q)
                r = cand[32:0];
        end
        return (r > 33'(bmsa_pkg::ERR_MAX)) ? bmsa_pkg::ERR_MAX : r[22:0];
    endfunction

    function automatic bmsa_pkg::result_t predict_stats(bmsa_pkg::item_t w);
        bmsa_pkg::result_t res;
        int lim;
        int t;
        int b;
        res = '0;
        lim = (bin_lim < NBINS) ? int'(bin_lim) : NBINS;
        if (w.cmd == bmsa_pkg::CMD_ACCUMULATE)
        begin
            t = w.truth_energy;
            b = t / 4096;
            if (b >= 0 && b < lim && bin_cnt[b] != bmsa_pkg::COUNT_MAX)
            begin
                bin_cnt[b] = bin_cnt[b] + 16'd1;
                clus_sum[b] = clus_sum[b] + 40'(w.cluster_energy);
                clus_sq[b] = clus_sq[b] + 62'(64'(w.cluster_energy) * 64'(w.cluster_energy));
                core_sum[b] = core_sum[b] + 40'(w.core_energy);
                core_sq[b] = core_sq[b] + 62'(64'(w.core_energy) * 64'(w.core_energy));
                res.accepted = 1'b1;
            end
        end
        else if (int'(w.read_bin) < lim)
        begin
            b = w.read_bin;
            res.accepted = 1'b1;
            res.sample_count = bin_cnt[b];
            res.mean_cluster = bin_mean(clus_sum[b], bin_cnt[b]);
            res.error_cluster = bin_stderr(clus_sum[b], clus_sq[b], bin_cnt[b]);
            res.mean_core = bin_mean(core_sum[b], bin_cnt[b]);
            res.error_core = bin_stderr(core_sum[b], core_sq[b], bin_cnt[b]);
        end
        return res;
    endfunction

    // result side: check and stall pattern
    initial
    begin
        int mode;
        int left;
        bmsa_pkg::result_t exp_r;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            result_taken = result_valid && !result_stall;
            if (result_taken)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word: expected none actual %p", $time, result);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result !== exp_r)
                    begin
                        errors++;
                        $display("%0t mismatch: expected %p actual %p", $time, exp_r, result);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(8, 80);
                end
                left--;
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 2) == 0);
                    2: result_stall <= ~result_stall;
                    default: result_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            item_taken = item_valid && !item_stall;
            if (item_taken || (result_valid && !result_stall) || psel)
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(bmsa_pkg::item_t w);
        bmsa_pkg::result_t exp_w;
        item <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        exp_w = predict_stats(w);
        pending_results.insert(pending_results.size(), exp_w);
    endtask

    task automatic sender_gap(int n);
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_bin_limit(logic [6:0] v);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(bmsa_pkg::CFG_REG_BIN_LIMIT) * 3'd4;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bin_lim = v;
    endtask

    function automatic bmsa_pkg::item_t acc_word(int truth, int clus, int core);
        bmsa_pkg::item_t w;
        w = '0;
        w.cmd = bmsa_pkg::CMD_ACCUMULATE;
        w.truth_energy = 24'(truth);
        w.cluster_energy = 24'(clus);
        w.core_energy = 24'(core);
        w.read_bin = 6'($urandom);
        return w;
    endfunction

    function automatic bmsa_pkg::item_t read_word(int b);
        bmsa_pkg::item_t w;
        w = bmsa_pkg::item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        w.cmd = bmsa_pkg::CMD_READ;
        w.read_bin = 6'(b);
        return w;
    endfunction

    function automatic bmsa_pkg::item_t random_word(int lim);
        int b;
        int t;
        int c;
        int k;
        int spread;
        if ($urandom_range(0, 9) == 0)
            return read_word($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            return bmsa_pkg::item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        b = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
        t = b * 4096 + $urandom_range(0, 4095);
        spread = 1 << $urandom_range(4, 23);
        c = $signed(24'($urandom_range(0, spread - 1) - spread / 2 + b * 8192));
        k = $signed(24'($urandom));
        return acc_word(t, c, k);
    endfunction

    task automatic test_directed();
        send_word(acc_word(8388607, 8388607, -8388608));
        send_word(acc_word(-8388608, 1, 1));
        send_word(acc_word(-4096, 5, 5));
        send_word(acc_word(-2048, -8388608, 8388607));
        send_word(acc_word(-1, 8388607, 0));
        send_word(acc_word(39 * 4096 + 4095, 100, -100));
        send_word(acc_word(40 * 4096, 7, 7));
        send_word(read_word(0));
        send_word(read_word(39));
        send_word(read_word(40));
        send_word(read_word(63));
        send_word(read_word(12));
        send_word(acc_word(5 * 4096, 12345, -54321));
        send_word(read_word(5));
        send_word(acc_word(5 * 4096 + 17, 12000, -50000));
        send_word(read_word(5));
        sender_gap(3);
    endtask

    task automatic test_extreme_bin();
        for (int i = 0; i < 24; i++)
            send_word(acc_word(4096 + (i * 171) % 4096, (i % 2) ? 8388607 : -8388608,
                               (i % 3) ? -8388608 : 8388607));
        send_word(read_word(1));
        drain();
    endtask

    task automatic test_random(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            repeat (burst)
            begin
                send_word(random_word(bin_lim < NBINS ? int'(bin_lim) : NBINS));
                sent++;
            end
            sender_gap($urandom_range(0, 6));
        end
    endtask

    task automatic test_limits();
        write_bin_limit(7'd1);
        send_word(acc_word(100, 300, -300));
        send_word(acc_word(4096, 1, 1));
        send_word(read_word(0));
        send_word(read_word(1));
        test_random(60);
        write_bin_limit(7'd0);
        send_word(acc_word(100, 1, 1));
        send_word(read_word(0));
        test_random(30);
        write_bin_limit(7'd127);
        send_word(acc_word(63 * 4096 + 4095, 9, 9));
        send_word(read_word(63));
        test_random(200);
        write_bin_limit(7'd64);
        test_random(200);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 40; i++)
            send_word(acc_word($urandom_range(0, 30) * 4096, $signed(24'($urandom)),
                               $signed(24'($urandom))));
        drain();
        test_random(100);
    endtask

    initial
    begin
        bin_lim = bmsa_pkg::BIN_LIMIT_RESET;
        for (int i = 0; i < NBINS; i++)
        begin
            bin_cnt[i] = '0;
            clus_sum[i] = '0;
            clus_sq[i] = '0;
            core_sum[i] = '0;
            core_sq[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_bin();
        test_random(420);
        test_backpressure();
        test_limits();
        write_bin_limit(7'd40);
        test_random(150);
        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bmsa_pkg.sv
rtl/bmsa_arith.sv
rtl/binned_mean_stderr_accumulator_top.sv
sim/tb_top.sv
